// ===== hw/rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg : shared types and constants for the ack retransmit tracker
// Field widths, register reset values, item kinds, result codes and the
// layout of one table entry.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_PENALTY  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BASE_TIMEOUT_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] HOP_PENALTY_RST  = 16'd100;

    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_ACK      = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    localparam logic [2:0] EV_REGISTERED = 3'd0;
    localparam logic [2:0] EV_FULL       = 3'd1;
    localparam logic [2:0] EV_ACK_MATCH  = 3'd2;
    localparam logic [2:0] EV_UNMATCHED  = 3'd3;
    localparam logic [2:0] EV_ACK_BAD    = 3'd4;
    localparam logic [2:0] EV_RETRANSMIT = 3'd5;
    localparam logic [2:0] EV_TIMED_OUT  = 3'd6;
    localparam logic [2:0] EV_TICK_DONE  = 3'd7;

    localparam int unsigned PROD_W = 24;   // hops x penalty
    localparam int unsigned TMO_W  = 25;   // base + hops x penalty

    typedef struct packed {
        logic [31:0] peer;
        logic [15:0] mtype;
        logic [63:0] stamp;
        logic [63:0] deadline;
        logic [7:0]  retries;
        logic [7:0]  limit;
        logic [7:0]  hops;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ===== hw/rtl/art_ram.sv =====
// ----------------------------------------------------------------------------
// art_ram : generic single write port RAM with registered read
// One write and one read address per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module art_ram #(
    parameter int unsigned WIDTH = art_pkg::ENTRY_W,
    parameter int unsigned DEPTH = art_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ack_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// ack_retransmit_tracker : table of messages awaiting acknowledgement
// Items are taken one at a time: a new input transfer is accepted only in the
// idle state, after the previous item has finished. Register items and acks
// with valid fields scan the slots through the entry RAM read port; a tick
// scans every slot. Output back-pressure stalls an item with a result to send.
// Reset: synchronous active-low; clears all valid bits, restores timeouts.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker #(
    parameter int unsigned TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [art_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [art_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // peer_id, msg_type, msg_timestamp, retry_limit, hops, now_ms
    input  logic [191:0]                     i_s_tdata,
    // kind, ack_fields_valid
    input  logic [2:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // slot, out_peer, out_type, out_timestamp, retries_done, zero pad
    output logic [127:0]                     o_m_tdata,
    // event_res
    output logic [2:0]                       o_m_tuser,
    output logic                             o_m_tlast
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_CALC,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [15:0]        r_base;
    logic [15:0]        r_penalty;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CW-1:0]      r_idx;
    logic [1:0]         r_kind;
    logic               r_flag;
    logic [31:0]        r_peer;
    logic [15:0]        r_type;
    logic [63:0]        r_stamp;
    logic [7:0]         r_limit;
    logic [7:0]         r_hops;
    logic [63:0]        r_now;
    logic               r_hit;
    logic [IW-1:0]      r_tgt;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic               r_retry;
    logic [art_pkg::PROD_W-1:0] r_prod;

    logic               r_out_valid;
    logic [2:0]         r_out_ev;
    logic [3:0]         r_out_slot;
    logic [31:0]        r_out_peer;
    logic [15:0]        r_out_type;
    logic [63:0]        r_out_stamp;
    logic [7:0]         r_out_retries;
    logic               r_out_last;

    logic [IW-1:0]      cur;
    logic               scan_done;
    logic               out_free;
    logic               key_eq;
    art_pkg::t_entry    rd;
    logic [art_pkg::ENTRY_W-1:0] ram_rdata;
    logic               ram_re;
    logic               ram_we;
    art_pkg::t_entry    ram_wdata;
    logic [art_pkg::TMO_W-1:0] tmo;
    logic [64:0]        dl_sum;
    logic [63:0]        dl;

    logic               emit;
    logic [2:0]         e_ev;
    logic [3:0]         e_slot;
    logic [31:0]        e_peer;
    logic [15:0]        e_type;
    logic [63:0]        e_stamp;
    logic [7:0]         e_retries;
    logic               e_last;

    assign cur       = r_idx[IW-1:0];
    assign scan_done = (r_idx == DEPTH_C);
    assign out_free  = !r_out_valid || i_m_tready;
    assign rd        = art_pkg::t_entry'(ram_rdata);
    assign key_eq    = (rd.peer == r_peer) && (rd.mtype == r_type) && (rd.stamp == r_stamp);

    // shared deadline unit: now + base + hops * penalty, saturating
    assign tmo    = art_pkg::TMO_W'(r_base) + art_pkg::TMO_W'(r_prod);
    assign dl_sum = {1'b0, r_now} + 65'(tmo);
    assign dl     = dl_sum[64] ? {64{1'b1}} : dl_sum[63:0];

    assign ram_re = (r_state == S_LOOK) && !scan_done && r_valid[cur];
    assign ram_we = (r_state == S_CALC) && out_free &&
                    ((r_kind == art_pkg::KIND_REGISTER) || r_retry);

    always_comb begin
        if (r_kind == art_pkg::KIND_REGISTER) begin
            ram_wdata = '{peer: r_peer, mtype: r_type, stamp: r_stamp, deadline: dl,
                          retries: 8'd0, limit: r_limit, hops: r_hops};
        end else begin
            ram_wdata          = rd;
            ram_wdata.retries  = rd.retries + 8'd1;
            ram_wdata.deadline = dl;
        end
    end

    always_comb begin
        emit      = 1'b0;
        e_ev      = art_pkg::EV_TICK_DONE;
        e_slot    = 4'd0;
        e_peer    = r_peer;
        e_type    = r_type;
        e_stamp   = r_stamp;
        e_retries = 8'd0;
        e_last    = 1'b1;
        case (r_state)
            S_CALC: begin
                emit   = out_free;
                e_slot = 4'(r_tgt);
                if (r_kind == art_pkg::KIND_REGISTER) begin
                    e_ev = art_pkg::EV_REGISTERED;
                end else begin
                    e_ev      = r_retry ? art_pkg::EV_RETRANSMIT : art_pkg::EV_TIMED_OUT;
                    e_peer    = rd.peer;
                    e_type    = rd.mtype;
                    e_stamp   = rd.stamp;
                    e_retries = r_retry ? rd.retries + 8'd1 : rd.retries;
                    e_last    = 1'b0;
                end
            end
            S_FINISH: begin
                case (r_kind)
                    art_pkg::KIND_REGISTER: begin
                        emit = out_free && !r_hit && !r_free_found;
                        e_ev = art_pkg::EV_FULL;
                    end
                    art_pkg::KIND_ACK: begin
                        emit = out_free;
                        if (!r_flag) begin
                            e_ev = art_pkg::EV_ACK_BAD;
                        end else if (r_hit) begin
                            e_ev      = art_pkg::EV_ACK_MATCH;
                            e_slot    = 4'(r_tgt);
                            e_peer    = rd.peer;
                            e_type    = rd.mtype;
                            e_stamp   = rd.stamp;
                            e_retries = rd.retries;
                        end else begin
                            e_ev = art_pkg::EV_UNMATCHED;
                        end
                    end
                    default: begin
                        emit    = out_free;
                        e_ev    = art_pkg::EV_TICK_DONE;
                        e_peer  = 32'd0;
                        e_type  = 16'd0;
                        e_stamp = 64'd0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_base      <= art_pkg::BASE_TIMEOUT_RST;
            r_penalty   <= art_pkg::HOP_PENALTY_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    art_pkg::CFG_BASE_TIMEOUT: r_base    <= i_cfg_wdata;
                    art_pkg::CFG_HOP_PENALTY:  r_penalty <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (emit) begin
                r_out_valid   <= 1'b1;
                r_out_ev      <= e_ev;
                r_out_slot    <= e_slot;
                r_out_peer    <= e_peer;
                r_out_type    <= e_type;
                r_out_stamp   <= e_stamp;
                r_out_retries <= e_retries;
                r_out_last    <= e_last;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind       <= i_s_tuser[1:0];
                        r_flag       <= i_s_tuser[2];
                        r_peer       <= i_s_tdata[31:0];
                        r_type       <= i_s_tdata[47:32];
                        r_stamp      <= i_s_tdata[111:48];
                        r_limit      <= i_s_tdata[119:112];
                        r_hops       <= i_s_tdata[127:120];
                        r_now        <= i_s_tdata[191:128];
                        r_idx        <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        case (i_s_tuser[1:0])
                            art_pkg::KIND_REGISTER: r_state <= S_LOOK;
                            art_pkg::KIND_TICK:     r_state <= S_LOOK;
                            art_pkg::KIND_ACK:      r_state <= i_s_tuser[2] ? S_LOOK : S_FINISH;
                            default:                r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (scan_done) begin
                        r_state <= S_FINISH;
                    end else if (r_valid[cur]) begin
                        r_state <= S_CHECK;
                    end else begin
                        if (r_kind == art_pkg::KIND_REGISTER && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= cur;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_CHECK: begin
                    if (r_kind == art_pkg::KIND_TICK) begin
                        if (r_now >= rd.deadline) begin
                            r_tgt   <= cur;
                            r_retry <= rd.retries < rd.limit;
                            r_prod  <= art_pkg::PROD_W'(rd.hops) * art_pkg::PROD_W'(r_penalty);
                            r_state <= S_CALC;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_LOOK;
                        end
                    end else if (key_eq) begin
                        r_hit   <= 1'b1;
                        r_tgt   <= cur;
                        r_state <= S_FINISH;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_LOOK;
                    end
                end
                S_CALC: begin
                    if (out_free) begin
                        if (r_kind == art_pkg::KIND_REGISTER) begin
                            r_valid[r_tgt] <= 1'b1;
                            r_state        <= S_IDLE;
                        end else begin
                            if (!r_retry) begin
                                r_valid[r_tgt] <= 1'b0;
                            end
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_FINISH: begin
                    case (r_kind)
                        art_pkg::KIND_REGISTER: begin
                            if (r_hit || r_free_found) begin
                                if (!r_hit) begin
                                    r_tgt <= r_free_idx;
                                end
                                r_prod  <= art_pkg::PROD_W'(r_hops) *
                                           art_pkg::PROD_W'(r_penalty);
                                r_state <= S_CALC;
                            end else if (out_free) begin
                                r_state <= S_IDLE;
                            end
                        end
                        art_pkg::KIND_ACK: begin
                            if (out_free) begin
                                if (r_flag && r_hit) begin
                                    r_valid[r_tgt] <= 1'b0;
                                end
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    art_ram #(
        .WIDTH (art_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tgt),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (cur),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_retries, r_out_stamp, r_out_type, r_out_peer, r_out_slot};
    assign o_m_tuser  = r_out_ev;
    assign o_m_tlast  = r_out_last;

    // only retransmit and time-out results sit inside a run
    a_last_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == ((r_out_ev != art_pkg::EV_RETRANSMIT) &&
                                        (r_out_ev != art_pkg::EV_TIMED_OUT))))
        else $error("tlast does not match result code");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev == art_pkg::EV_TICK_DONE) |->
            (r_out_slot == 4'd0 && r_out_retries == 8'd0))
        else $error("tick done result carries slot or retry data");

    // an entry written to the table is live afterwards
    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(r_tgt)])
        else $error("table entry written but not marked valid");

    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOOK || r_state == S_CHECK) && r_kind == art_pkg::KIND_REGISTER &&
         r_free_found) |-> !r_valid[r_free_idx])
        else $error("chosen free slot is occupied");

endmodule
